FILE: hw/rtl/trail_ring_lookahead_point_macros.svh
// Assertion macros for the port-level checker file.
// Each use stands on a line of its own inside a module that has clk and arst_n.
`ifndef TRAIL_RING_LOOKAHEAD_POINT_MACROS_SVH
`define TRAIL_RING_LOOKAHEAD_POINT_MACROS_SVH

// property checked outside reset
`define TLAP_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define TLAP_CHECK_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/tlap_pkg.sv
// ----------------------------------------------------------------------------
// tlap_pkg
// Types, codes and defaults shared by the trail ring lookahead point block.
// ----------------------------------------------------------------------------
package tlap_pkg;

	localparam int TLAP_DEPTH = 64;

	// result status codes
	localparam logic [2:0] ST_APPENDED = 3'd0;
	localparam logic [2:0] ST_FOUND    = 3'd1;
	localparam logic [2:0] ST_END      = 3'd2;
	localparam logic [2:0] ST_EMPTY    = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	localparam logic KIND_APPEND = 1'b0;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] pos_speed;
		logic        [5:0]  start_index;
		logic        [31:0] distance;
	} req_word_t;

	typedef struct packed {
		logic        [2:0]  status;
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic signed [31:0] out_speed;
		logic        [5:0]  seg_index;
		logic        [31:0] remainder;
	} rsp_word_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_APPEND, S_READ, S_ABSD, S_SQX, S_SQY, S_SQINIT,
		S_SQRT, S_CHECK, S_DIV, S_LX, S_LY, S_POST
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       append;
		logic       rd;
		logic       absd;
		logic       sqx;
		logic       sqy;
		logic       sq_init;
		logic       sq_step;
		logic       div_init;
		logic       div_step;
		logic       lx;
		logic       ly;
		logic       adv;
		logic       post;
		logic [2:0] code;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic kind;
		logic empty;
		logic short_seg;
		logic stay;
		logic cnt_last;
		logic iter_done;
		logic out_free;
	} dp_stat_t;

endpackage

FILE: hw/rtl/trail_ring_lookahead_point.sv
// ----------------------------------------------------------------------------
// trail_ring_lookahead_point
// Ring of trail points with append and lookahead point search.
//
//   channel  dir  payload      handshake
//   req      in   req_word_t   req_valid / req_stall
//   rsp      out  rsp_word_t   rsp_valid / rsp_stall
//
// Append: the word passes the dispatch and append states to the result register.
// Lookahead: each walked segment is read, differenced, squared and rooted (33 steps
// of the bit-serial square root), then the 32-step divide and interpolation run on
// the segment that holds the point. The shared root/divide unit sets the walk time.
// Reset clears the write pointer and fill count; no memory clearing pass.
// A stalled result holds the block before it returns to idle.
// ----------------------------------------------------------------------------
module trail_ring_lookahead_point import tlap_pkg::*; #(
	parameter int DEPTH = TLAP_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_word_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_word_t rsp
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	tlap_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	tlap_datapath #(.DEPTH(DEPTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall)
	);

endmodule

FILE: hw/rtl/tlap_ctrl.sv
// ----------------------------------------------------------------------------
// tlap_ctrl
// Sequencer: walks append and lookahead words through the datapath steps.
// ----------------------------------------------------------------------------
module tlap_ctrl import tlap_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t     state_q, state_d;
	logic [2:0] code_q, code_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= ST_APPENDED;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		code_d  = code_q;
		case (state_q)
			S_IDLE:     if (req_valid) state_d = S_DISPATCH;
			S_DISPATCH: begin
				if (stat.kind == KIND_APPEND) begin
					state_d = S_APPEND;
				end else if (stat.empty) begin
					state_d = S_POST;
					code_d  = ST_EMPTY;
				end else begin
					state_d = S_READ;
				end
			end
			S_APPEND: begin
				state_d = S_POST;
				code_d  = ST_APPENDED;
			end
			S_READ:   state_d = S_ABSD;
			S_ABSD:   state_d = S_SQX;
			S_SQX:    state_d = S_SQY;
			S_SQY:    state_d = S_SQINIT;
			S_SQINIT: state_d = S_SQRT;
			S_SQRT:   if (stat.iter_done) state_d = S_CHECK;
			S_CHECK: begin
				if (stat.short_seg) begin
					state_d = S_DIV;
					code_d  = ST_FOUND;
				end else if (stat.stay) begin
					state_d = S_POST;
					code_d  = ST_END;
				end else if (stat.cnt_last) begin
					state_d = S_POST;
					code_d  = ST_NOTFOUND;
				end else begin
					state_d = S_READ;
				end
			end
			S_DIV:  if (stat.iter_done) state_d = S_LX;
			S_LX:   state_d = S_LY;
			S_LY:   state_d = S_POST;
			S_POST: if (stat.out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		cmd.code = code_q;
		case (state_q)
			S_IDLE:   cmd.load = req_valid;
			S_APPEND: cmd.append = 1'b1;
			S_READ:   cmd.rd = 1'b1;
			S_ABSD:   cmd.absd = 1'b1;
			S_SQX:    cmd.sqx = 1'b1;
			S_SQY:    cmd.sqy = 1'b1;
			S_SQINIT: cmd.sq_init = 1'b1;
			S_SQRT:   cmd.sq_step = 1'b1;
			S_CHECK: begin
				cmd.div_init = stat.short_seg;
				cmd.adv      = !stat.short_seg && !stat.stay;
			end
			S_DIV:    cmd.div_step = 1'b1;
			S_LX:     cmd.lx = 1'b1;
			S_LY:     cmd.ly = 1'b1;
			S_POST:   cmd.post = stat.out_free;
			default:  cmd = '0;
		endcase
	end

	assign req_stall = (state_q != S_IDLE);

endmodule

FILE: hw/rtl/tlap_datapath.sv
// ----------------------------------------------------------------------------
// tlap_datapath
// Trail ring memories, walk registers, shared multiplier, root and divide
// iterations, and the result register.
// ----------------------------------------------------------------------------
module tlap_datapath import tlap_pkg::*; #(
	parameter int DEPTH = TLAP_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  req_word_t req,
	input  dp_cmd_t   cmd,
	output dp_stat_t  stat,
	output rsp_word_t rsp,
	output logic      rsp_valid,
	input  logic      rsp_stall
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = AW + 1;
	localparam int MW = (CW > 6) ? CW : 6;

	// trail ring
	logic [31:0] mem_x [DEPTH];
	logic [31:0] mem_y [DEPTH];
	logic [31:0] mem_z [DEPTH];
	logic [31:0] mem_sp [DEPTH];

	logic          kind_q;
	logic [31:0]   px_q, py_q, pz_q, psp_q;
	logic [AW-1:0] wp_q;
	logic [CW-1:0] fill_q;
	logic [AW-1:0] i_q;
	logic [31:0]   rem_q;
	logic [CW-1:0] cnt_q;

	logic signed [31:0] xi_q, xn_q, yi_q, yn_q;
	logic [31:0]        zi_q, spi_q;
	logic [31:0]        ax_q, ay_q;
	logic               dxneg_q, dyneg_q;

	logic [63:0] prod_q, a2_q;
	logic [65:0] rad_q;
	logic [36:0] srem_q;
	logic [33:0] root_q;
	logic [5:0]  iter_q;
	logic [34:0] r_q;
	logic [31:0] frac_q;
	logic [31:0] ox_q;

	rsp_word_t rsp_q;
	rsp_word_t rsp_c;
	logic      rsp_valid_q;

	// next index along the trail
	logic [AW-1:0] n_c, cand_c;
	logic          last_i_c, full_c;
	always_comb begin
		last_i_c = (CW'(i_q) == fill_q - CW'(1));
		full_c   = (fill_q == CW'(DEPTH));
		if (last_i_c) cand_c = full_c ? '0 : i_q;
		else          cand_c = i_q + AW'(1);
		n_c = (cand_c == wp_q) ? i_q : cand_c;
	end

	// start clamp
	logic [AW-1:0] start_c;
	assign start_c = (MW'(req.start_index) >= MW'(fill_q)) ? AW'(fill_q - CW'(1))
	                                                      : AW'(req.start_index);

	// coordinate differences
	logic signed [32:0] dx_c, dy_c;
	assign dx_c = xn_q - xi_q;
	assign dy_c = yn_q - yi_q;

	// shared 32x32 multiplier
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod_c;
	always_comb begin
		mul_a = cmd.sqy || cmd.ly ? ay_q : ax_q;
		mul_b = (cmd.lx || cmd.ly) ? frac_q : mul_a;
		prod_c = mul_a * mul_b;
	end

	// root step
	logic [36:0] srem_sh, trial;
	assign srem_sh = {srem_q[34:0], rad_q[65:64]};
	assign trial   = {1'b0, root_q, 2'b01};

	// divide step
	logic [34:0] r_sh, len_e;
	assign r_sh  = {r_q[33:0], 1'b0};
	assign len_e = {1'b0, root_q};

	logic [31:0] off_c;
	assign off_c = prod_q[63:32];

	// ring write and two read ports
	always_ff @(posedge clk) begin
		if (cmd.append) begin
			mem_x[wp_q]  <= px_q;
			mem_y[wp_q]  <= py_q;
			mem_z[wp_q]  <= pz_q;
			mem_sp[wp_q] <= psp_q;
		end
		if (cmd.rd) begin
			xi_q  <= mem_x[i_q];
			yi_q  <= mem_y[i_q];
			zi_q  <= mem_z[i_q];
			spi_q <= mem_sp[i_q];
			xn_q  <= mem_x[n_c];
			yn_q  <= mem_y[n_c];
		end
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
		end else if (cmd.append) begin
			wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			if (fill_q != CW'(DEPTH)) fill_q <= fill_q + CW'(1);
		end
	end

	// walk and arithmetic registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= req.kind;
			px_q   <= req.pos_x;
			py_q   <= req.pos_y;
			pz_q   <= req.pos_z;
			psp_q  <= req.pos_speed;
			i_q    <= start_c;
			rem_q  <= req.distance;
			cnt_q  <= '0;
		end
		if (cmd.absd) begin
			ax_q    <= dx_c[32] ? 32'(-dx_c) : dx_c[31:0];
			ay_q    <= dy_c[32] ? 32'(-dy_c) : dy_c[31:0];
			dxneg_q <= dx_c[32];
			dyneg_q <= dy_c[32];
		end
		if (cmd.sqx || cmd.sqy || cmd.lx || cmd.ly) prod_q <= prod_c;
		if (cmd.sqy) a2_q <= prod_q;
		if (cmd.ly) ox_q <= dxneg_q ? xi_q - off_c : xi_q + off_c;
		// 33 root steps, one per bit pair of the 66-bit radicand
		if (cmd.sq_init) begin
			rad_q  <= 66'(a2_q) + 66'(prod_q);
			srem_q <= '0;
			root_q <= '0;
			iter_q <= 6'd32;
		end
		if (cmd.sq_step) begin
			rad_q  <= {rad_q[63:0], 2'b00};
			iter_q <= iter_q - 6'd1;
			if (srem_sh >= trial) begin
				srem_q <= srem_sh - trial;
				root_q <= {root_q[32:0], 1'b1};
			end else begin
				srem_q <= srem_sh;
				root_q <= {root_q[32:0], 1'b0};
			end
		end
		if (cmd.div_init) begin
			r_q    <= {3'b000, rem_q};
			frac_q <= '0;
			iter_q <= 6'd31;
		end
		if (cmd.div_step) begin
			iter_q <= iter_q - 6'd1;
			if (r_sh >= len_e) begin
				r_q    <= r_sh - len_e;
				frac_q <= {frac_q[30:0], 1'b1};
			end else begin
				r_q    <= r_sh;
				frac_q <= {frac_q[30:0], 1'b0};
			end
		end
		if (cmd.adv) begin
			rem_q <= rem_q - root_q[31:0];
			i_q   <= n_c;
			cnt_q <= cnt_q + CW'(1);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.post) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// result word assembly
	always_comb begin
		rsp_c        = '0;
		rsp_c.status = cmd.code;
		if (cmd.code == ST_FOUND || cmd.code == ST_END) begin
			rsp_c.out_x     = (cmd.code == ST_FOUND) ? ox_q : xi_q;
			rsp_c.out_y     = (cmd.code == ST_END) ? yi_q :
			                  (dyneg_q ? yi_q - off_c : yi_q + off_c);
			rsp_c.out_z     = zi_q;
			rsp_c.out_speed = spi_q;
			rsp_c.seg_index = 6'(i_q);
			rsp_c.remainder = rem_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.post) rsp_q <= rsp_c;
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		stat.kind      = kind_q;
		stat.empty     = (fill_q == '0);
		stat.short_seg = ({2'b00, rem_q} < root_q);
		stat.stay      = (n_c == i_q);
		stat.cnt_last  = (cnt_q == fill_q - CW'(1));
		stat.iter_done = (iter_q == '0);
		stat.out_free  = !rsp_valid_q || !rsp_stall;
	end

endmodule

FILE: hw/rtl/tlap_checker.sv
// ----------------------------------------------------------------------------
// tlap_checker
// Port-level checks on the trail ring lookahead point block.
// ----------------------------------------------------------------------------
`include "trail_ring_lookahead_point_macros.svh"

module tlap_checker import tlap_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_stall,
	input req_word_t req,
	input logic      rsp_valid,
	input logic      rsp_stall,
	input rsp_word_t rsp
);

	// a stalled result word holds
	`TLAP_CHECK(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "rsp word changed while stalled")

	// an accepted word makes the block busy
	`TLAP_CHECK(a_busy, req_valid && !req_stall |=> req_stall, "not busy after accept")

	// a result only appears out of a busy block
	`TLAP_CHECK(a_rsp_src, $rose(rsp_valid) |-> $past(req_stall), "result without work")

	// status-only results carry zero payload
	`TLAP_CHECK(a_zero, rsp_valid && (rsp.status == ST_APPENDED || rsp.status == ST_EMPTY || rsp.status == ST_NOTFOUND) |-> rsp.out_x == '0 && rsp.out_y == '0 && rsp.out_z == '0 && rsp.out_speed == '0 && rsp.seg_index == '0 && rsp.remainder == '0, "nonzero payload on status result")

	// no result during reset
	`TLAP_CHECK_ALWAYS(a_rst, !arst_n |-> !rsp_valid, "result valid in reset")

endmodule

bind trail_ring_lookahead_point tlap_checker u_chk (.*);

FILE: dv/trail_lookahead_checker.sv
// ----------------------------------------------------------------------------
// trail_lookahead_checker
// Watches the req and rsp channels of the trail ring lookahead block. It keeps
// its own copy of the point ring, predicts one rsp word per accepted req word
// and compares the words field by field, in order.
// ----------------------------------------------------------------------------
module trail_lookahead_checker import tlap_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_stall,
	input  req_word_t req,
	input  logic      rsp_valid,
	input  logic      rsp_stall,
	input  rsp_word_t rsp,
	output int        fail_count,
	output int        pending
);

	logic signed [31:0] ring_x[TLAP_DEPTH];
	logic signed [31:0] ring_y[TLAP_DEPTH];
	logic signed [31:0] ring_z[TLAP_DEPTH];
	logic signed [31:0] ring_speed[TLAP_DEPTH];
	int                 wr_ptr;
	int                 fill;
	rsp_word_t          expected_rsp[$];

	assign pending = expected_rsp.size();

	task automatic report(input string what);
		$display("MISMATCH @%0t: %s", $realtime, what);
		fail_count++;
	endtask

	// next point along the trail; staying put means end of trail
	function automatic int next_point(input int i);
		int cand;
		cand = i + 1;
		if (fill == 0)
			return 0;
		if (i == fill - 1) begin
			if (fill == TLAP_DEPTH)
				cand = 0;
			else
				return i;
		end
		if (cand == wr_ptr)
			cand = i;
		return cand;
	endfunction

	// floor square root of a 66-bit value, bit-serial
	function automatic logic [63:0] root_floor(input logic [65:0] v);
		logic [67:0] ve, acc, root, trial;
		ve = {2'b0, v};
		acc = 0;
		root = 0;
		for (int k = 33; k >= 0; k--) begin
			acc = (acc << 2) | ve[2*k +: 2];
			root = root << 1;
			trial = (root << 1) | 68'd1;
			if (acc >= trial) begin
				acc = acc - trial;
				root = root | 68'd1;
			end
		end
		return root[63:0];
	endfunction

	function automatic logic [63:0] seg_length(input int i, input int n);
		longint      dx, dy;
		logic [63:0] ax, ay;
		logic [65:0] sq;
		dx = longint'(ring_x[n]) - longint'(ring_x[i]);
		dy = longint'(ring_y[n]) - longint'(ring_y[i]);
		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;
		sq = {2'b0, ax * ax} + {2'b0, ay * ay};
		return root_floor(sq);
	endfunction

	// start + |d| * frac / 2^32, offset truncated toward zero
	function automatic logic [31:0] blend(input logic signed [31:0] a,
			input logic signed [31:0] b, input logic [31:0] frac);
		longint      d;
		logic [63:0] ad, off;
		d = longint'(b) - longint'(a);
		ad = (d < 0) ? -d : d;
		off = (ad * {32'b0, frac}) >> 32;
		return (d < 0) ? 32'(longint'(a) - longint'(off)) : 32'(longint'(a) + longint'(off));
	endfunction

	task automatic predict_word(input req_word_t w, output rsp_word_t e);
		int          i, n;
		logic [63:0] left, len, r;
		logic [31:0] frac;
		e = '0;
		// append: store and advance
		if (w.kind == KIND_APPEND) begin
			ring_x[wr_ptr] = w.pos_x;
			ring_y[wr_ptr] = w.pos_y;
			ring_z[wr_ptr] = w.pos_z;
			ring_speed[wr_ptr] = w.pos_speed;
			wr_ptr = (wr_ptr + 1) % TLAP_DEPTH;
			if (fill < TLAP_DEPTH)
				fill++;
			e.status = ST_APPENDED;
			return;
		end
		if (fill == 0) begin
			e.status = ST_EMPTY;
			return;
		end
		i = w.start_index;
		if (i >= fill)
			i = fill - 1;
		left = {32'b0, w.distance};
		// walk segments
		for (int c = 0; c < fill; c++) begin
			n = next_point(i);
			len = seg_length(i, n);
			if (left < len) begin
				r = left;
				frac = 0;
				for (int b = 0; b < 32; b++) begin
					r = r << 1;
					frac = frac << 1;
					if (r >= len) begin
						r = r - len;
						frac[0] = 1'b1;
					end
				end
				e.status = ST_FOUND;
				e.out_x = blend(ring_x[i], ring_x[n], frac);
				e.out_y = blend(ring_y[i], ring_y[n], frac);
				e.out_z = ring_z[i];
				e.out_speed = ring_speed[i];
				e.seg_index = 6'(i);
				e.remainder = left[31:0];
				return;
			end
			if (n == i) begin
				e.status = ST_END;
				e.out_x = ring_x[i];
				e.out_y = ring_y[i];
				e.out_z = ring_z[i];
				e.out_speed = ring_speed[i];
				e.seg_index = 6'(i);
				e.remainder = left[31:0];
				return;
			end
			left = left - len;
			i = n;
		end
		e.status = ST_NOTFOUND;
	endtask

	// compare first (older word), then predict the newly accepted one
	always @(posedge clk or negedge arst_n) begin
		rsp_word_t e, got;
		if (!arst_n) begin
			wr_ptr = 0;
			fill = 0;
			expected_rsp.delete();
		end else begin
			if (rsp_valid && !rsp_stall) begin
				got = rsp;
				if (expected_rsp.size() == 0) begin
					report("rsp word with nothing expected");
				end else begin
					e = expected_rsp.pop_front();
					if (got.status !== e.status)
						report($sformatf("status %0d, expected %0d", got.status, e.status));
					if (got.out_x !== e.out_x)
						report($sformatf("out_x %h, expected %h", got.out_x, e.out_x));
					if (got.out_y !== e.out_y)
						report($sformatf("out_y %h, expected %h", got.out_y, e.out_y));
					if (got.out_z !== e.out_z)
						report($sformatf("out_z %h, expected %h", got.out_z, e.out_z));
					if (got.out_speed !== e.out_speed)
						report($sformatf("out_speed %h, expected %h", got.out_speed,
							e.out_speed));
					if (got.seg_index !== e.seg_index)
						report($sformatf("seg_index %0d, expected %0d", got.seg_index,
							e.seg_index));
					if (got.remainder !== e.remainder)
						report($sformatf("remainder %h, expected %h", got.remainder,
							e.remainder));
				end
			end
			if (req_valid && !req_stall) begin
				predict_word(req, e);
				expected_rsp.push_back(e);
			end
		end
	end

	initial fail_count = 0;

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives append and lookahead words into the trail ring block under three
// idle/stall mixes: directed corner words first, then random trails built
// from short steps with some full-range noise. The checker judges every rsp.
// ----------------------------------------------------------------------------
module testbench;
	import tlap_pkg::*;

	localparam int  NUM_RANDOM = 270;
	localparam int  DRAIN_CYCLES = 3000;
	localparam longint CYCLE_LIMIT = 6000000;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	req_word_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_word_t rsp;
	int        fail_count;
	int        pending;
	int        send_idle_pct;
	int        recv_stall_pct;
	longint    cycles;
	logic signed [31:0] cur_x, cur_y;

	trail_ring_lookahead_point u_top (
		.clk, .arst_n, .req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp
	);

	trail_lookahead_checker u_checker (
		.clk, .arst_n, .req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp,
		.fail_count, .pending
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// receiver stall
	always @(posedge clk)
		rsp_stall <= ($urandom_range(99) < recv_stall_pct);

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// send one word, with random idle cycles ahead of it
	task automatic send_word(input req_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= w;
		req_valid <= 1'b1;
		do @(negedge clk); while (req_stall);
		@(posedge clk);
	endtask

	task automatic append_point(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input logic [31:0] sp);
		req_word_t    w;
		logic [223:0] noise;
		noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		w = noise[$bits(req_word_t)-1:0];
		w.kind = KIND_APPEND;
		w.pos_x = x;
		w.pos_y = y;
		w.pos_z = z;
		w.pos_speed = sp;
		send_word(w);
	endtask

	task automatic lookahead(input logic [5:0] idx, input logic [31:0] span);
		req_word_t    w;
		logic [223:0] noise;
		noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		w = noise[$bits(req_word_t)-1:0];
		w.kind = ~KIND_APPEND;
		w.start_index = idx;
		w.distance = span;
		send_word(w);
	endtask

	function automatic logic [31:0] rand_dist();
		case ($urandom_range(9))
			0: return 32'd0;
			1: return $urandom;
			2: return 32'hFFFF_FFFF;
			default: return $urandom_range(0, 32'h0040_0000);
		endcase
	endfunction

	initial begin
		logic [31:0] sx, sy;
		cycles = 0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		send_idle_pct = 10;
		recv_stall_pct = 76;
		cur_x = 0;
		cur_y = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty ring, extremes, clamp, zero-length and reversed segments
		lookahead(6'd0, 32'd100);
		append_point(32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		lookahead(6'd63, 32'd0);
		lookahead(6'd0, 32'hFFFF_FFFF);
		append_point(32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 32'h0002_0000);
		lookahead(6'd0, 32'h0002_8000);
		lookahead(6'd0, 32'h0005_0000);
		lookahead(6'd63, 32'h0000_0001);
		append_point(32'h0003_0000, 32'h0004_0000, 32'hFFFF_FFFF, 32'h0);
		append_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		append_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 32'hFFFF_FFFF);
		lookahead(6'd2, 32'h0000_0000);
		lookahead(6'd1, 32'h0001_0000);
		lookahead(6'd3, 32'hFFFF_FFFF);
		lookahead(6'd3, 32'h8000_0000);
		append_point(32'hFFFF_0000, 32'hFFFF_0000, 32'h0, 32'h0);
		lookahead(6'd4, 32'h0000_8000);
		lookahead(6'd0, 32'hFFFF_FFFF);
		lookahead(6'd40, 32'h0000_1000);

		// random trails: mostly short steps, some full-range points
		for (int k = 0; k < NUM_RANDOM; k++) begin
			if (k == NUM_RANDOM / 3) begin
				send_idle_pct = 76;
				recv_stall_pct = 10;
			end else if (k == 2 * NUM_RANDOM / 3) begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			// hold off until the block has drained
			if (k == NUM_RANDOM / 2) begin
				req_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			if ($urandom_range(99) < 55) begin
				case ($urandom_range(9))
					0: begin
						sx = $urandom;
						sy = $urandom;
					end
					1: begin
						sx = cur_x;
						sy = cur_y;
					end
					default: begin
						sx = cur_x + 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh10_0000);
						sy = cur_y + 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh10_0000);
					end
				endcase
				cur_x = sx;
				cur_y = sy;
				append_point(sx, sy, $urandom, $urandom);
			end else begin
				lookahead(6'($urandom_range(63)), rand_dist());
			end
		end
		req_valid <= 1'b0;
		@(posedge clk);

		// drain
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/tlap_pkg.sv
hw/rtl/tlap_ctrl.sv
hw/rtl/tlap_datapath.sv
hw/rtl/trail_ring_lookahead_point.sv
hw/rtl/tlap_checker.sv
dv/trail_lookahead_checker.sv
dv/testbench.sv
